@@ rtl/u8sd_pkg.sv @@
package u8sd_pkg;

  localparam int unsigned CP_W       = 21;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned PEND_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned QDEPTH_DEF = 4;

  // Sequence lengths
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  // One decoded result
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic             err;
    logic [LEN_W-1:0] len;
  } result_t;

  // Queue entry: the results that one byte causes
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  // Outcome of decoding a byte as a lead
  typedef struct packed {
    logic              emit;
    result_t           res;
    logic [PEND_W-1:0] pend;
    logic [LEN_W-1:0]  len;
    logic [CP_W-1:0]   pv;
  } lead_t;

  localparam result_t ERR_RES = '{cp: '0, err: 1'b1, len: LEN_NONE};

  function automatic lead_t lead_decode(input logic [BYTE_W-1:0] b);
    lead_t l;
    l = '0;
    if (b[7] == 1'b0) begin
      // plain ASCII passes through
      l.emit = 1'b1;
      l.res  = '{cp: {13'd0, b}, err: 1'b0, len: LEN_ONE};
    end else if (b[7:5] == 3'b110) begin
      if (b[4:1] == 4'd0) begin
        // two-byte overlong lead
        l.emit = 1'b1;
        l.res  = ERR_RES;
      end else begin
        l.pend = 2'd1;
        l.len  = LEN_TWO;
        l.pv   = {16'd0, b[4:0]};
      end
    end else if (b[7:4] == 4'b1110) begin
      l.pend = 2'd2;
      l.len  = LEN_THREE;
      l.pv   = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      l.pend = 2'd3;
      l.len  = LEN_FOUR;
      l.pv   = {18'd0, b[2:0]};
    end else begin
      // stray continuation or invalid lead
      l.emit = 1'b1;
      l.res  = ERR_RES;
    end
    return l;
  endfunction

endpackage

@@ rtl/u8sd_front.sv @@
module u8sd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [u8sd_pkg::BYTE_W-1:0]  in_byte,
  input  logic                         in_end_of_stream,
  output logic                         q_push,
  output u8sd_pkg::entry_t             q_entry
);
  import u8sd_pkg::*;

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CP_W-1:0]   pv_r, pv_nxt;

  lead_t           lead;
  logic            cont;
  logic [1:0]      n;
  result_t         r0, r1;
  logic [CP_W-1:0] pv_shift;

  assign lead     = lead_decode(in_byte);
  assign cont     = (in_byte[7:6] == 2'b10);
  assign pv_shift = {pv_r[CP_W-7:0], in_byte[5:0]};

  // Classify the beat against the open sequence
  always_comb begin
    n        = 2'd0;
    r0       = ERR_RES;
    r1       = ERR_RES;
    pend_nxt = pend_r;
    len_nxt  = len_r;
    pv_nxt   = pv_r;
    if (pend_r != 2'd0 && cont) begin
      // shift a continuation into the accumulator
      pend_nxt = pend_r - 2'd1;
      pv_nxt   = pv_shift;
      if (pend_r == 2'd1) begin
        r0       = '{cp: pv_shift, err: 1'b0, len: len_r};
        n        = 2'd1;
        len_nxt  = LEN_NONE;
        pv_nxt   = '0;
      end
    end else begin
      if (pend_r != 2'd0) begin
        // broken sequence: report it, then decode the byte as a lead
        n = 2'd1;
      end
      pend_nxt = lead.pend;
      len_nxt  = lead.len;
      pv_nxt   = lead.pv;
      if (lead.emit) begin
        if (n == 2'd0) r0 = lead.res;
        else           r1 = lead.res;
        n = n + 2'd1;
      end
    end
    // flush an open sequence at end of stream
    if (in_end_of_stream) begin
      if (pend_nxt != 2'd0) begin
        n = n + 2'd1;
      end
      pend_nxt = '0;
      len_nxt  = LEN_NONE;
      pv_nxt   = '0;
    end
  end

  assign q_push        = accept && (n != 2'd0);
  assign q_entry.two   = (n == 2'd2);
  assign q_entry.r0    = r0;
  assign q_entry.r1    = r1;

  // Advance decoder state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      len_r  <= LEN_NONE;
      pv_r   <= '0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      len_r  <= len_nxt;
      pv_r   <= pv_nxt;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd0) |-> (len_r == LEN_NONE && pv_r == '0))
    else $error("idle decoder holds stale sequence data");

  a_len_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 2'd0) |-> (len_r > {1'b0, pend_r}))
    else $error("open sequence shorter than pending count");

  a_eos_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_stream) |=> (pend_r == 2'd0))
    else $error("sequence left open after end of stream");

endmodule

@@ rtl/u8sd_queue.sv @@
module u8sd_queue #(
  parameter int unsigned DEPTH = u8sd_pkg::QDEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8sd_pkg::entry_t push_entry,
  input  logic             pop,
  output u8sd_pkg::entry_t head,
  output logic             empty,
  output logic             full
);
  import u8sd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  entry_t         mem_r [DEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == FULLC);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  // Store the entry at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_entry;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == LAST) ? '0 : wr_r + PW'(1);
      if (do_pop)  rd_r <= (rd_r == LAST) ? '0 : rd_r + PW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULLC)
    else $error("queue occupancy beyond depth");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("queue count missed a push");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_r == rd_r))
    else $error("empty queue with pointers apart");

endmodule

@@ rtl/u8sd_back.sv @@
module u8sd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  u8sd_pkg::entry_t              head,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [u8sd_pkg::CP_W-1:0]     out_code_point,
  output logic                          out_is_error,
  output logic [u8sd_pkg::LEN_W-1:0]    out_seq_length,
  output logic                          out_last_of_run
);
  import u8sd_pkg::*;

  logic    valid_r;
  result_t res_r;
  logic    last_r;
  logic    sel_r;
  logic    load;
  logic    at_end;

  assign load   = (!valid_r || pop) && !q_empty;
  assign at_end = sel_r || !head.two;
  assign q_pop  = load && at_end;
  assign empty  = !valid_r;

  assign out_code_point  = res_r.cp;
  assign out_is_error    = res_r.err;
  assign out_seq_length  = res_r.len;
  assign out_last_of_run = last_r;

  // Hold the output beat until it is taken
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= sel_r ? head.r1 : head.r0;
      last_r <= at_end;
    end
  end

  // Step through the results of the head entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      if (load)     valid_r <= 1'b1;
      else if (pop) valid_r <= 1'b0;
      if (load)     sel_r   <= !at_end;
    end
  end

  a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (!q_empty && head.two))
    else $error("second result selected without a paired entry");

  a_sel_first: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !at_end) |=> (valid_r && !last_r))
    else $error("first of a pair marked as last");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && res_r.err) |-> (res_r.cp == '0 && res_r.len == LEN_NONE))
    else $error("error beat carries data");

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// Path: a byte is classified combinationally, stored in the entry queue, then loaded into the output register.
// Throughput: one byte per cycle while full is low and one result per cycle while pop is held; a byte with two
//   results takes one output beat for each, absorbed by the entry queue between decoder and output.
// full follows the full flag of the QDEPTH-entry queue.
// Reset (rst_n low, synchronous) closes any open sequence and empties the queue.
module utf8_stream_decoder #(
  parameter int unsigned QDEPTH = u8sd_pkg::QDEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [u8sd_pkg::BYTE_W-1:0]   in_byte,
  input  logic                          in_end_of_stream,
  output logic                          empty,
  input  logic                          pop,
  output logic [u8sd_pkg::CP_W-1:0]     out_code_point,
  output logic                          out_is_error,
  output logic [u8sd_pkg::LEN_W-1:0]    out_seq_length,
  output logic                          out_last_of_run
);
  import u8sd_pkg::*;

  logic   accept;
  logic   q_push, q_pop, q_empty, q_full;
  entry_t q_entry, q_head;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Decode and classify input beats
  u8sd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_push           (q_push),
    .q_entry          (q_entry)
  );

  // Buffer result entries between the two sides
  u8sd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // Serialize entries into output beats
  u8sd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_code_point  (out_code_point),
    .out_is_error    (out_is_error),
    .out_seq_length  (out_seq_length),
    .out_last_of_run (out_last_of_run)
  );

endmodule
